[rtl/bpic_pkg.sv]
// Bit-permuted index counter: shared package.
// Payload structs, register and action codes, table sweep states, destination lookup.
// No dependencies.
`default_nettype none

package bpic_pkg;

  localparam int unsigned DATA_W     = 64;
  localparam int unsigned ACT_W      = 3;
  localparam int unsigned RANK_W     = 7;
  localparam int unsigned BIU_W      = 7;
  localparam int unsigned DEST_W     = 6;
  localparam int unsigned PERM_WORDS = 6;
  localparam int unsigned PERM_VEC_W = PERM_WORDS * DATA_W;
  localparam int unsigned CFG_IDX_W  = 3;

  // action codes
  localparam logic [ACT_W-1:0] ACT_LOAD     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INC      = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SET_NAT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SET_PERM = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ     = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PERM_WORD0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERM_WORD5  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BITS_IN_USE = 3'd6;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [DATA_W-1:0] value;
    logic [RANK_W-1:0] rank_bits;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] natural_out;
    logic [DATA_W-1:0] permuted_out;
    logic              at_end;
  } out_item_t;

  // inverse table rebuild sequencer
  typedef enum logic [1:0] {
    TS_INV,
    TS_GRP,
    TS_RUN
  } tbl_state_t;

  typedef struct packed {
    logic ready;     // tables valid, items may enter
    logic lock_clr;  // a register write landed, drop all locks
  } tbl_status_t;

  // permuted position of natural bit i
  function automatic logic [DEST_W-1:0] dest_of(input logic [PERM_VEC_W-1:0] vec,
                                                input int unsigned i);
    dest_of = vec[DEST_W*i +: DEST_W];
  endfunction

endpackage

`default_nettype wire

[rtl/bpic_tables.sv]
// Bit-permuted index counter: configuration registers and inverse lookup tables.
// Rebuilds the inverse and rank-group tables by a sweep after reset or a register write.
// Depends on bpic_pkg.
`default_nettype none

module bpic_tables #(
  parameter int unsigned INDEX_BITS = 64
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          cfg_we,
  input  logic [bpic_pkg::CFG_IDX_W-1:0]                cfg_index,
  input  logic [bpic_pkg::DATA_W-1:0]                   cfg_wdata,
  output logic [bpic_pkg::PERM_VEC_W-1:0]               perm_vec,
  output logic [$clog2(INDEX_BITS+1)-1:0]               used_bits,
  output logic [INDEX_BITS-1:0][$clog2(INDEX_BITS)-1:0] inv_pos,
  output logic [INDEX_BITS-1:0]                         inv_hit,
  output logic [INDEX_BITS-1:0][$clog2(INDEX_BITS)-1:0] grp_pos,
  output logic [INDEX_BITS-1:0]                         grp_hit,
  output bpic_pkg::tbl_status_t                         status
);
  import bpic_pkg::*;

  localparam int unsigned POS_W = $clog2(INDEX_BITS);
  localparam int unsigned CNT_W = $clog2(INDEX_BITS + 1);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(INDEX_BITS - 1);

  logic [PERM_WORDS-1:0][DATA_W-1:0] perm_words_r;
  logic [BIU_W-1:0]                  biu_r;
  tbl_state_t                        state_r, state_nxt;
  logic [POS_W-1:0]                  cnt_r, cnt_nxt;
  logic                              cfg_hit;
  logic [DEST_W-1:0]                 sweep_dest;
  logic                              sweep_live;
  logic                              dest_in_range;
  logic [POS_W-1:0]                  grp_key;

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index) inside
        [CFG_PERM_WORD0:CFG_PERM_WORD5], CFG_BITS_IN_USE: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perm_words_r <= '0;
      biu_r        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        [CFG_PERM_WORD0:CFG_PERM_WORD5]: perm_words_r[cfg_index] <= cfg_wdata;
        CFG_BITS_IN_USE: biu_r <= cfg_wdata[BIU_W-1:0];
        default: ;
      endcase
    end
  end

  assign perm_vec  = perm_words_r;
  assign used_bits = (biu_r > BIU_W'(INDEX_BITS)) ? CNT_W'(INDEX_BITS) : CNT_W'(biu_r);

  // sequencer: inverse pass, then rank-group pass, then run
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      TS_INV: begin
        cnt_nxt = cnt_r + POS_W'(1);
        if (cnt_r == LAST_POS) begin
          state_nxt = TS_GRP;
          cnt_nxt   = '0;
        end
      end
      TS_GRP: begin
        cnt_nxt = cnt_r + POS_W'(1);
        if (cnt_r == LAST_POS) begin
          state_nxt = TS_RUN;
          cnt_nxt   = '0;
        end
      end
      TS_RUN: ;
      default: begin
        state_nxt = TS_INV;
        cnt_nxt   = '0;
      end
    endcase
    if (cfg_hit) begin
      state_nxt = TS_INV;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TS_INV;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign sweep_dest    = dest_of(perm_vec, 32'(cnt_r));
  assign sweep_live    = (CNT_W'(cnt_r) < used_bits);
  assign dest_in_range = ({1'b0, sweep_dest} < (DEST_W + 1)'(INDEX_BITS));
  // inverse of a position with no preimage is position 0
  assign grp_key       = inv_hit[cnt_r] ? inv_pos[cnt_r] : '0;

  // ascending sweep: the last writer is the largest source index
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      inv_hit <= '0;
      grp_hit <= '0;
    end else begin
      if (state_r == TS_INV && sweep_live && dest_in_range) begin
        inv_hit[sweep_dest[POS_W-1:0]] <= 1'b1;
      end
      if (state_r == TS_GRP && sweep_live) begin
        grp_hit[grp_key] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == TS_INV && sweep_live && dest_in_range) begin
      inv_pos[sweep_dest[POS_W-1:0]] <= cnt_r;
    end
    if (state_r == TS_GRP && sweep_live) begin
      grp_pos[grp_key] <= cnt_r;
    end
  end

  assign status.ready    = (state_r == TS_RUN);
  assign status.lock_clr = cfg_hit;

endmodule

`default_nettype wire

[rtl/bpic_step.sv]
// Bit-permuted index counter: next-state logic for one transaction.
// Masked increment, load, rank writes, permutation crossbar.
// Depends on bpic_pkg.
`default_nettype none

module bpic_step #(
  parameter int unsigned INDEX_BITS = 64
) (
  input  bpic_pkg::in_item_t                           item,
  input  logic [INDEX_BITS-1:0]                        nat,
  input  logic [INDEX_BITS-1:0]                        perm,
  input  logic [INDEX_BITS-1:0]                        lock,
  input  logic [bpic_pkg::PERM_VEC_W-1:0]              perm_vec,
  input  logic [$clog2(INDEX_BITS+1)-1:0]              used_bits,
  input  logic [INDEX_BITS-1:0][$clog2(INDEX_BITS)-1:0] inv_pos,
  input  logic [INDEX_BITS-1:0]                        inv_hit,
  input  logic [INDEX_BITS-1:0][$clog2(INDEX_BITS)-1:0] grp_pos,
  input  logic [INDEX_BITS-1:0]                        grp_hit,
  output logic [INDEX_BITS-1:0]                        nat_nxt,
  output logic [INDEX_BITS-1:0]                        perm_nxt,
  output logic [INDEX_BITS-1:0]                        lock_nxt,
  output logic                                         at_end
);
  import bpic_pkg::*;

  localparam int unsigned CNT_W = $clog2(INDEX_BITS + 1);
  localparam logic [INDEX_BITS-1:0] END_MARK = {1'b0, {(INDEX_BITS-1){1'b1}}};

  // natural-order bits to permuted order; destinations past the index width drop
  function automatic logic [INDEX_BITS-1:0] scatter(input logic [INDEX_BITS-1:0] src,
                                                    input logic [PERM_VEC_W-1:0] vec);
    logic [INDEX_BITS-1:0] res;
    res = '0;
    for (int j = 0; j < INDEX_BITS; j++) begin
      for (int i = 0; i < INDEX_BITS; i++) begin
        if (src[i] && (dest_of(vec, i) == DEST_W'(j))) begin
          res[j] = 1'b1;
        end
      end
    end
    return res;
  endfunction

  logic [INDEX_BITS-1:0] inuse, rmask, vsh, vload;
  logic [INDEX_BITS-1:0] unl, zeros, zm1, first, clr;
  logic [INDEX_BITS-1:0] sc_src, sc_a, sc_b;
  logic [INDEX_BITS-1:0] perm_rn, nat_rp, lock_rp;
  logic [CNT_W-1:0]      rank_n, shamt;
  logic [DATA_W-1:0]     vshift;
  logic                  wrap;

  always_comb begin
    rank_n = (item.rank_bits > RANK_W'(used_bits)) ? used_bits : CNT_W'(item.rank_bits);
    shamt  = used_bits - rank_n;
    vshift = item.value << shamt;
    vsh    = vshift[INDEX_BITS-1:0];
    vload  = item.value[INDEX_BITS-1:0];
    for (int i = 0; i < INDEX_BITS; i++) begin
      inuse[i] = (CNT_W'(i) < used_bits);
      rmask[i] = inuse[i] && (CNT_W'(i) >= shamt);
    end
  end

  // ripple increment over unlocked bits: lowest unlocked zero is set,
  // unlocked ones below it clear
  always_comb begin
    unl   = ~lock & inuse;
    zeros = unl & ~nat;
    zm1   = zeros - INDEX_BITS'(1);
    first = zeros & ~zm1;
    clr   = unl & zm1 & ~zeros;
    wrap  = ~|zeros;
  end

  assign sc_src = (item.action == ACT_LOAD) ? (vload & inuse) : clr;
  assign sc_a   = scatter(sc_src, perm_vec);
  assign sc_b   = scatter(first, perm_vec);

  // rank writes that collide resolve to the highest rank position
  always_comb begin
    for (int j = 0; j < INDEX_BITS; j++) begin
      perm_rn[j] = (inv_hit[j] && rmask[inv_pos[j]]) ? vsh[inv_pos[j]] : perm[j];
      nat_rp[j]  = (grp_hit[j] && rmask[grp_pos[j]]) ? vsh[grp_pos[j]] : nat[j];
      lock_rp[j] = lock[j] | (grp_hit[j] && rmask[grp_pos[j]]);
    end
  end

  always_comb begin
    nat_nxt  = nat;
    perm_nxt = perm;
    lock_nxt = lock;
    at_end   = 1'b0;
    unique case (item.action)
      ACT_LOAD: begin
        nat_nxt  = vload;
        perm_nxt = sc_a;
      end
      ACT_INC: begin
        if (wrap) begin
          nat_nxt  = END_MARK;
          perm_nxt = END_MARK;
          at_end   = 1'b1;
        end else begin
          nat_nxt  = (nat & ~clr) | first;
          perm_nxt = (perm & ~sc_a) | sc_b;
        end
      end
      ACT_SET_NAT: begin
        lock_nxt = lock | rmask;
        nat_nxt  = (nat & ~rmask) | (vsh & rmask);
        perm_nxt = perm_rn;
      end
      ACT_SET_PERM: begin
        lock_nxt = lock_rp;
        nat_nxt  = nat_rp;
        perm_nxt = (perm & ~rmask) | (vsh & rmask);
      end
      ACT_READ: ;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/bit_permuted_index_counter_unit.sv]
// Bit-permuted index counter: top level.
// Handshake, input and result registers, index and lock state.
// Depends on bpic_pkg, bpic_tables, bpic_step.
`default_nettype none

// Index generator for transposed FFT data. Keeps a natural index, the same
// index with its bits moved by a configured permutation, and a lock mask.
// Each transaction loads, increments (ripple over unlocked bits only), sets
// the top rank bits in natural or permuted order (locking them), or reads.
// A wrapping increment loads the end marker (all index bits set but the top)
// into both indices and flags at_end. Throughput is one transaction per
// cycle: the input register feeds a combinational update of the index and
// lock registers (masked carry chain plus permutation crossbar), and the
// result register takes the outcome, so a result passes the input register
// and then the result register, and a stalled output does not block intake
// until both registers are full. Permuted-rank writes need the inverse
// permutation, and its tables are rebuilt by a sweep (inverse pass, then
// rank-group pass) after reset and after every write to a configuration
// register; in_ready stays low for that time. Configuration writes clear all
// locks and leave the indices as they are. Write configuration only while no
// transaction is in flight.
module bit_permuted_index_counter_unit #(
  parameter int unsigned INDEX_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bpic_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bpic_pkg::out_item_t            out_item,
  input  logic                           cfg_we,
  input  logic [bpic_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpic_pkg::DATA_W-1:0]    cfg_wdata
);
  import bpic_pkg::*;

  localparam int unsigned POS_W = $clog2(INDEX_BITS);
  localparam int unsigned CNT_W = $clog2(INDEX_BITS + 1);

  // configuration and lookup tables
  logic [PERM_VEC_W-1:0]            perm_vec;
  logic [CNT_W-1:0]                 used_bits;
  logic [INDEX_BITS-1:0][POS_W-1:0] inv_pos;
  logic [INDEX_BITS-1:0][POS_W-1:0] grp_pos;
  logic [INDEX_BITS-1:0]            inv_hit;
  logic [INDEX_BITS-1:0]            grp_hit;
  tbl_status_t                      tbl_status;

  // input stage
  logic     s1_valid_r, s1_valid_nxt;
  in_item_t s1_item_r;

  // result stage
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  // index state
  logic [INDEX_BITS-1:0] nat_r, nat_nxt;
  logic [INDEX_BITS-1:0] perm_r, perm_nxt;
  logic [INDEX_BITS-1:0] lock_r, lock_nxt;
  logic                  step_end;

  logic advance;  // input stage retires into the result register
  logic take;     // transaction accepted on the input side

  bpic_tables #(
    .INDEX_BITS (INDEX_BITS)
  ) u_tables (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .perm_vec  (perm_vec),
    .used_bits (used_bits),
    .inv_pos   (inv_pos),
    .inv_hit   (inv_hit),
    .grp_pos   (grp_pos),
    .grp_hit   (grp_hit),
    .status    (tbl_status)
  );

  bpic_step #(
    .INDEX_BITS (INDEX_BITS)
  ) u_step (
    .item      (s1_item_r),
    .nat       (nat_r),
    .perm      (perm_r),
    .lock      (lock_r),
    .perm_vec  (perm_vec),
    .used_bits (used_bits),
    .inv_pos   (inv_pos),
    .inv_hit   (inv_hit),
    .grp_pos   (grp_pos),
    .grp_hit   (grp_hit),
    .nat_nxt   (nat_nxt),
    .perm_nxt  (perm_nxt),
    .lock_nxt  (lock_nxt),
    .at_end    (step_end)
  );

  // The input stage frees up in the same cycle it retires, so a full
  // pipeline keeps flowing as long as the result side drains.
  always_comb begin
    advance       = s1_valid_r && (!out_valid_r || out_ready);
    in_ready      = rst_n && tbl_status.ready && (!s1_valid_r || advance);
    take          = in_valid && in_ready;
    s1_valid_nxt  = take || (s1_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      nat_r       <= '0;
      perm_r      <= '0;
      lock_r      <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        nat_r  <= nat_nxt;
        perm_r <= perm_nxt;
      end
      // user keeps register writes to idle (unenforced); they drop all locks
      if (tbl_status.lock_clr) begin
        lock_r <= '0;
      end else if (advance) begin
        lock_r <= lock_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_item_r.natural_out  <= DATA_W'(nat_nxt);
      out_item_r.permuted_out <= DATA_W'(perm_nxt);
      out_item_r.at_end       <= step_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

[rtl/bpic_checker.sv]
// Bit-permuted index counter: port-level checker and its bind to the top level.
// Depends on bpic_pkg and bit_permuted_index_counter_unit.
`default_nettype none

module bpic_checker #(
  parameter int unsigned INDEX_BITS = 64
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input bpic_pkg::out_item_t            out_item,
  input logic                           cfg_we,
  input logic [bpic_pkg::CFG_IDX_W-1:0] cfg_index
);
  import bpic_pkg::*;

  localparam logic [DATA_W-1:0] END_MARK   = DATA_W'({(INDEX_BITS-1){1'b1}});
  localparam logic [DATA_W-1:0] INDEX_MASK = DATA_W'({INDEX_BITS{1'b1}});

  // table rebuild after reset keeps input closed
  ap_reset_rebuild: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open right after reset");

  // table rebuild after a register write keeps input closed
  ap_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index <= CFG_BITS_IN_USE) |=> !in_ready)
    else $error("input open right after configuration write");

  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  ap_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.at_end |->
      (out_item.natural_out == END_MARK) && (out_item.permuted_out == END_MARK))
    else $error("end flag without end marker");

  ap_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_item.natural_out & ~INDEX_MASK) == '0) &&
                  ((out_item.permuted_out & ~INDEX_MASK) == '0))
    else $error("index bits above index width");

endmodule

bind bit_permuted_index_counter_unit bpic_checker #(
  .INDEX_BITS (INDEX_BITS)
) u_bpic_checker (.*);

`default_nettype wire

[tb/tb.sv]
// Testbench for bit_permuted_index_counter_unit: directed and random transactions checked
// against an in-bench predictor of the natural index, permuted index and lock mask.
// Depends on bpic_pkg and bit_permuted_index_counter_unit; self-contained otherwise.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpic_pkg::*;

  localparam int unsigned HOLD_CYCLES   = 80;        // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES = 4;         // result reg + input reg, with margin
  localparam int unsigned MAX_PRINTS    = 40;
  localparam int unsigned LIMIT_NS      = 5_000_000; // far past a slow run

  localparam logic [DATA_W-1:0] END_MARK = 64'h7fff_ffff_ffff_ffff;
  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  // spare action codes, decoded as read
  localparam logic [ACT_W-1:0] ACT_SPARE_LO  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_MID = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI  = 3'd7;

  typedef enum {MAP_IDENT, MAP_REVERSE, MAP_SHUFFLE, MAP_RAW, MAP_FLAT} map_kind_t;
  typedef enum {RX_OPEN, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_t;

  // DUT ports; every input has a known value from time zero
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_wdata = '0;

  // Predictor copy of the block's configuration and index state
  logic [PERM_VEC_W-1:0] perm_map  = '0;
  logic [BIU_W-1:0]      span_reg  = '0;
  logic [DATA_W-1:0]     idx_nat   = '0;
  logic [DATA_W-1:0]     idx_perm  = '0;
  logic [DATA_W-1:0]     lock_bits = '0;

  // Expected index results, oldest first
  out_item_t   expected_results[$];
  out_item_t   want_res;
  int unsigned mismatches   = 0;
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;

  // Sender burst state and receiver stall state
  int unsigned burst_left   = 0;
  int unsigned hold_asked   = 0;  // bumped by a test to request a hold-off
  int unsigned hold_served  = 0;
  int unsigned hold_left    = 0;
  int unsigned mode_left    = 0;
  int unsigned pattern_tick = 0;
  rx_mode_t    rx_mode      = RX_OPEN;

  bit_permuted_index_counter_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Permuted position of natural bit i: 6-bit fields packed across the six words.
  function automatic logic [DEST_W-1:0] dest_pos(int unsigned i);
    return perm_map[DEST_W*i +: DEST_W];
  endfunction

  // Applies one transaction to the predicted state and returns the result it must produce.
  function automatic out_item_t advance_index(in_item_t it);
    int unsigned n, r, p, q, i, j;
    logic        wrapped;
    logic        v;
    out_item_t   res;
    n       = (span_reg > DATA_W) ? DATA_W : span_reg;  // oversized span clamps
    r       = (it.rank_bits > n) ? n : it.rank_bits;
    wrapped = 1'b0;
    case (it.action)
      ACT_LOAD: begin
        idx_nat  = it.value;
        idx_perm = '0;
        for (i = 0; i < n; i++)
          if (it.value[i]) idx_perm[dest_pos(i)] = 1'b1;
      end
      ACT_INC: begin
        // ripple over unlocked bits; the first clear one absorbs the carry
        wrapped = 1'b1;
        for (i = 0; i < n && wrapped; i++) begin
          if (!lock_bits[i]) begin
            if (idx_nat[i]) begin
              idx_nat[i]              = 1'b0;
              idx_perm[dest_pos(i)]   = 1'b0;
            end else begin
              idx_nat[i]              = 1'b1;
              idx_perm[dest_pos(i)]   = 1'b1;
              wrapped                 = 1'b0;
            end
          end
        end
        if (wrapped) begin
          idx_nat  = END_MARK;
          idx_perm = END_MARK;
        end
      end
      ACT_SET_NAT, ACT_SET_PERM: begin
        for (i = 0; i < r; i++) begin
          p = n - r + i;
          v = it.value[i];
          if (it.action == ACT_SET_NAT) begin
            lock_bits[p]          = 1'b1;
            idx_nat[p]            = v;
            idx_perm[dest_pos(p)] = v;
          end else begin
            // inverse image: last natural bit mapping to p, bit 0 if none does
            q = 0;
            for (j = 0; j < n; j++)
              if (dest_pos(j) == p) q = j;
            lock_bits[q] = 1'b1;
            idx_nat[q]   = v;
            idx_perm[p]  = v;
          end
        end
      end
      default: ;  // read and the spare codes leave the state alone
    endcase
    res.natural_out  = idx_nat;
    res.permuted_out = idx_perm;
    res.at_end       = wrapped;
    return res;
  endfunction

  // Builds a packed destination table. Reverse and shuffle act on the low span bits only.
  function automatic logic [PERM_VEC_W-1:0] make_map(map_kind_t kind, int unsigned span);
    logic [PERM_VEC_W-1:0] m;
    int unsigned           order[DATA_W];
    int unsigned           i, j, t, lim;
    lim = (span > DATA_W) ? DATA_W : span;
    for (i = 0; i < DATA_W; i++) order[i] = i;
    case (kind)
      MAP_REVERSE: for (i = 0; i < lim; i++) order[i] = lim - 1 - i;
      MAP_SHUFFLE: begin
        for (i = lim; i > 1; i--) begin
          j            = $urandom_range(0, i - 1);
          t            = order[i-1];
          order[i-1]   = order[j];
          order[j]     = t;
        end
      end
      MAP_FLAT: for (i = 0; i < DATA_W; i++) order[i] = 0;  // every bit lands on 0
      default: ;
    endcase
    for (i = 0; i < DATA_W; i++) m[DEST_W*i +: DEST_W] = order[i][DEST_W-1:0];
    if (kind == MAP_RAW)  // arbitrary words: duplicates and holes in the mapping
      for (i = 0; i < PERM_WORDS; i++) m[DATA_W*i +: DATA_W] = {$urandom, $urandom};
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: stall modes change at random; a requested hold-off overrides
  // them and is counted here.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left   = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(8, 64);
    end
    mode_left--;
    pattern_tick++;
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:    out_ready <= 1'b1;
        RX_COIN:    out_ready <= ($urandom_range(0, 1) == 1);
        RX_PATTERN: out_ready <= ((pattern_tick % 5) < 3);
        default:    out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every result transaction is matched against the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("tb: mismatch on result %0d, %0s: got %h, want %h",
               results_seen, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_item.natural_out, '0);
      end else begin
        want_res = expected_results.pop_front();
        if (out_item.natural_out !== want_res.natural_out)
          report_mismatch("natural_out", out_item.natural_out, want_res.natural_out);
        if (out_item.permuted_out !== want_res.permuted_out)
          report_mismatch("permuted_out", out_item.permuted_out, want_res.permuted_out);
        if (out_item.at_end !== want_res.at_end)
          report_mismatch("at_end", DATA_W'(out_item.at_end), DATA_W'(want_res.at_end));
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and configuration
  // ---------------------------------------------------------------------------

  // Offers one transaction; a new burst may open with a gap of idle cycles.
  // Valid stays up across back-to-back transactions and drops only in a gap.
  task automatic send_item(logic [ACT_W-1:0] act, logic [DATA_W-1:0] val,
                           logic [RANK_W-1:0] rb);
    in_item_t    item;
    int unsigned gap;
    item.action    = act;
    item.value     = val;
    item.rank_bits = rb;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (in_ready !== 1'b1);
    expected_results.push_back(advance_index(item));
    items_sent++;
  endtask

  // Lowers valid and waits until every expected result is in, plus the pipe depth.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_BITS_IN_USE) span_reg = data[BIU_W-1:0];
    else perm_map[DATA_W*idx +: DATA_W] = data;
    lock_bits = '0;  // any register write drops the locks
  endtask

  // Writes all seven registers once the block is idle.
  task automatic configure(map_kind_t kind, logic [BIU_W-1:0] span);
    logic [PERM_VEC_W-1:0] map;
    int unsigned           k;
    map = make_map(kind, span);
    drain_results();
    for (k = 0; k < PERM_WORDS; k++)
      write_reg(CFG_IDX_W'(CFG_PERM_WORD0 + k), map[DATA_W*k +: DATA_W]);
    write_reg(CFG_BITS_IN_USE, {{(DATA_W-BIU_W){1'b0}}, span});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly counter sweeps as an FFT transpose would issue them: a start index
  // with a run of ones at the bottom, sometimes a rank fix, then increments.
  // The rest is random transactions of any action.
  task automatic run_sweeps(int unsigned count);
    int unsigned       sent0, steps, lim, k;
    logic [DATA_W-1:0] start;
    sent0 = items_sent;
    lim   = (span_reg > DATA_W) ? DATA_W : span_reg;
    while (items_sent - sent0 < count) begin
      if ($urandom_range(0, 9) < 8) begin
        k     = $urandom_range(0, lim);
        start = {$urandom, $urandom} | ((64'd1 << k) - 64'd1);
        send_item(ACT_LOAD, start, RANK_W'($urandom_range(0, 64)));
        if ($urandom_range(0, 3) == 0)
          send_item(($urandom_range(0, 1) == 1) ? ACT_SET_NAT : ACT_SET_PERM,
                    {$urandom, $urandom},
                    RANK_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 64)
                                                        : $urandom_range(0, 4)));
        steps = $urandom_range(1, 24);
        repeat (steps)
          send_item(($urandom_range(0, 9) == 0) ? ACT_READ : ACT_INC,
                    {$urandom, $urandom}, RANK_W'($urandom_range(0, 64)));
      end else begin
        send_item(ACT_W'($urandom_range(0, 7)), {$urandom, $urandom},
                  RANK_W'($urandom_range(0, 64)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset configuration: zero span, so increments always hit the end marker
  // and rank actions do nothing.
  task automatic test_reset_state();
    send_item(ACT_READ, '0, 0);
    send_item(ACT_LOAD, ALL_ONES, 64);
    send_item(ACT_INC, '0, 0);
    send_item(ACT_SET_NAT, ALL_ONES, 64);
    send_item(ACT_SET_PERM, ALL_ONES, 127);
    send_item(ACT_SPARE_HI, ALL_ONES, 0);
  endtask

  // Identity map over 64 bits: full wrap, the step past the end marker,
  // fully locked counter, spare codes.
  task automatic test_wrap_and_locks();
    configure(MAP_IDENT, 64);
    send_item(ACT_LOAD, ALL_ONES, 0);
    send_item(ACT_INC, '0, 0);
    send_item(ACT_INC, ALL_ONES, 127);
    send_item(ACT_LOAD, '0, 64);
    send_item(ACT_SET_NAT, ALL_ONES, 64);  // locks every bit
    send_item(ACT_INC, '0, 0);
    send_item(ACT_READ, ALL_ONES, 64);
    send_item(ACT_SPARE_LO, ALL_ONES, 64);
    send_item(ACT_SPARE_MID, '0, 0);
  endtask

  // Bit reversal: permuted rank through the inverse map, rank count above span.
  task automatic test_rank_orders();
    configure(MAP_REVERSE, 64);
    send_item(ACT_SET_PERM, 64'ha, 4);
    send_item(ACT_INC, '0, 0);
    send_item(ACT_LOAD, 64'h0000_0000_ffff_ffff, 0);
    send_item(ACT_SET_NAT, '0, 100);  // clamps to the span, locks all
    send_item(ACT_INC, '0, 0);
  endtask

  // All bits map to position 0: positions with no inverse fall back to bit 0,
  // position 0 resolves to the highest natural bit.
  task automatic test_broken_permutation();
    configure(MAP_FLAT, 64);
    send_item(ACT_SET_PERM, 64'h5, 3);
    send_item(ACT_SET_PERM, {$urandom, $urandom}, 64);
    send_item(ACT_INC, '0, 0);
  endtask

  // Span register above the index width behaves as the full width.
  task automatic test_oversized_span();
    configure(MAP_IDENT, 127);
    send_item(ACT_LOAD, ALL_ONES, 0);
    send_item(ACT_INC, '0, 0);
  endtask

  task automatic test_random_bijections();
    repeat (4) begin
      configure(MAP_SHUFFLE, BIU_W'($urandom_range(2, 16)));
      run_sweeps(50);
    end
    configure(MAP_SHUFFLE, 64);
    run_sweeps(50);
    configure(MAP_SHUFFLE, 63);
    run_sweeps(50);
  endtask

  task automatic test_random_reversals();
    int unsigned spans[5] = '{1, 2, 5, 32, 64};
    foreach (spans[s]) begin
      configure(MAP_REVERSE, BIU_W'(spans[s]));
      run_sweeps(40);
    end
  endtask

  task automatic test_random_raw_maps();
    repeat (5) begin
      configure(MAP_RAW, BIU_W'($urandom_range(0, 64)));
      run_sweeps(40);
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so both internal registers fill and in_ready drops.
  task automatic test_backpressure();
    repeat (4) begin
      configure(MAP_SHUFFLE, BIU_W'($urandom_range(3, 12)));
      run_sweeps(10);
      hold_asked++;
      run_sweeps(40);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset once, then the tests in turn, then drain and report.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // in_ready stays low through the table sweep after reset; send_item waits on it
    test_reset_state();
    test_wrap_and_locks();
    test_rank_orders();
    test_broken_permutation();
    test_oversized_span();
    test_random_bijections();
    test_random_reversals();
    test_random_raw_maps();
    test_backpressure();
    drain_results();
    if (mismatches == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  // Watchdog against a hung handshake
  initial begin
    #(LIMIT_NS);
    $display("tb: FAIL");
    $finish;
  end

endmodule
